// ===== src/cerg_pkg.sv =====
// shared types, constants and helper functions for the chacha20 entropy random generator
// no dependencies; imported by cerg_round_unit, cerg_core and the top level
package cerg_pkg;

  localparam int DOUBLE_ROUNDS  = 10;
  localparam int STEPS          = DOUBLE_ROUNDS * 8;
  localparam int STEP_W         = $clog2(STEPS);
  localparam int BUFFER_BYTES   = 32;
  localparam int ENTROPY_TARGET = 256;
  localparam int PHASE_MOD      = 31;

  localparam logic [31:0] GOLDEN = 32'h9E3779B9;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646E;
  localparam logic [31:0] SIGMA2 = 32'h79622D32;
  localparam logic [31:0] SIGMA3 = 32'h6B206574;

  localparam logic [4:0] ROT_P0   = 5'd16;
  localparam logic [4:0] ROT_P1   = 5'd12;
  localparam logic [4:0] ROT_P2   = 5'd8;
  localparam logic [4:0] ROT_P3   = 5'd7;
  localparam logic [4:0] STIR_ROT = 5'd7;

  localparam logic [1:0] PHASE_0 = 2'd0;
  localparam logic [1:0] PHASE_1 = 2'd1;
  localparam logic [1:0] PHASE_2 = 2'd2;
  localparam logic [1:0] PHASE_3 = 2'd3;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_KEY,
    ST_MIX_STIR,
    ST_REFILL,
    ST_READ,
    ST_DONE
  } fsm_state_t;

  function automatic word_t rotl32(input word_t v, input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

endpackage

// ===== src/cerg_round_unit.sv =====
// one quarter-round step (add, xor, rotate) applied to all four lanes of the state
// depends on cerg_pkg
module cerg_round_unit import cerg_pkg::*; (
  input  block_t     st,
  input  logic       diag,
  input  logic [1:0] phase,
  output block_t     nxt
);

  logic [1:0] lane;
  logic [3:0] a_idx, b_idx, c_idx, d_idx;
  logic [3:0] x_idx, y_idx, z_idx;
  logic [4:0] rot;
  word_t      sum;

  always_comb begin
    unique case (phase)
      PHASE_0: rot = ROT_P0;
      PHASE_1: rot = ROT_P1;
      PHASE_2: rot = ROT_P2;
      PHASE_3: rot = ROT_P3;
      default: rot = ROT_P0;
    endcase
  end

  always_comb begin
    nxt   = st;
    lane  = '0;
    a_idx = '0;
    b_idx = '0;
    c_idx = '0;
    d_idx = '0;
    x_idx = '0;
    y_idx = '0;
    z_idx = '0;
    sum   = '0;
    for (int i = 0; i < 4; i++) begin
      lane  = 2'(i);
      // diagonal rounds shift the b, c and d rows by one, two and three lanes
      a_idx = {2'b00, lane};
      b_idx = {2'b01, lane + {1'b0, diag}};
      c_idx = {2'b10, lane + {diag, 1'b0}};
      d_idx = {2'b11, lane + {diag, diag}};
      if (phase[0]) begin
        x_idx = c_idx;
        y_idx = d_idx;
        z_idx = b_idx;
      end else begin
        x_idx = a_idx;
        y_idx = b_idx;
        z_idx = d_idx;
      end
      sum        = st[x_idx] + st[y_idx];
      nxt[x_idx] = sum;
      nxt[z_idx] = rotl32(st[z_idx] ^ sum, rot);
    end
  end

endmodule

// ===== src/cerg_core.sv =====
// iterative chacha block core: one quarter-round step per cycle over four lanes
// depends on cerg_pkg and cerg_round_unit
module cerg_core import cerg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  block_t       init,
  output block_t       block,
  output core_status_t status
);

  block_t            work;
  block_t            work_next;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;

  cerg_round_unit u_round (
    .st    (work),
    .diag  (step[2]),
    .phase (step[1:0]),
    .nxt   (work_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= init;
    end else if (busy) begin
      work <= work_next;
    end
  end

  // feed-forward of the input block
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      block[i] = work[i] + init[i];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== src/chacha20_entropy_random_generator.sv =====
// top level: chacha20 random byte generator with entropy mixing and key erasure
// depends on cerg_pkg and cerg_core
//
// usage
//   input beats arrive on s_axis: tuser selects the kind (0 mixes the entropy byte in
//   tdata[7:0], 1 asks for one random byte), tlast marks the final byte of an entropy
//   batch, tdata[16:8] carries the batch's entropy credit, used on that final byte.
//   every input beat yields exactly one output beat on m_axis carrying the random byte
//   (zero for a mix), the ready flag and the credited entropy count.
//   one item is handled at a time; s_axis_tready is high only while the block is idle.
//   a mix passes through ST_MIX_KEY, ST_MIX_STIR and ST_DONE before m_axis_tvalid is set; a
//   request served from the 32-byte buffer passes through ST_READ and ST_DONE, and one that
//   needs a new block first waits in ST_REFILL while the block core runs 80 quarter-round
//   steps (one step of all four lanes per cycle).
//   a result waiting on a stalled m_axis does not stop the next item being taken; that
//   item only waits in its final cycle until the output register is free.
//   reset (synchronous, active high) restores the sigma constants, clears the key,
//   counter, buffer fill, entropy count and batch position.
module chacha20_entropy_random_generator import cerg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // entropy_byte[7:0], entropy_credit[16:8], zero pad
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // random_byte[7:0], ready_res[8], entropy_count[17:9]
);

  fsm_state_t   state, state_next;
  block_t       cipher_state;
  word_t        out_buffer [8];
  logic [5:0]   bytes_available;
  logic [8:0]   credited_bits;
  logic [31:0]  batch_position;
  logic [4:0]   rotate_phase;

  logic         item_req;
  logic [7:0]   item_byte;
  logic         item_last;
  logic [8:0]   item_bits;
  logic [7:0]   res_byte;

  logic         accept;
  logic         core_start;
  logic         out_load;
  logic         buf_empty;
  block_t       core_block;
  core_status_t core_status;

  logic [2:0]   slot;
  logic [3:0]   key_idx;
  word_t        mix_word;
  logic [9:0]   room;
  logic [8:0]   credit_next;
  logic [4:0]   rd_pos;
  word_t        rd_word;

  cerg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (core_start),
    .init   (cipher_state),
    .block  (core_block),
    .status (core_status)
  );

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign buf_empty = (bytes_available == 6'd0) || (bytes_available > 6'(BUFFER_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    core_start    = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (!s_axis_tuser) begin
            state_next = ST_MIX_KEY;
          end else if (buf_empty) begin
            core_start = 1'b1;
            state_next = ST_REFILL;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_MIX_KEY:  state_next = ST_MIX_STIR;
      ST_MIX_STIR: state_next = ST_DONE;
      ST_REFILL: begin
        if (core_status.done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // mixing, credit and buffer read-position arithmetic
  always_comb begin
    slot     = batch_position[2:0];
    key_idx  = {1'b0, slot} + 4'd4;
    mix_word = rotl32({24'd0, item_byte} + GOLDEN + batch_position, rotate_phase + 5'd1);
    room     = (credited_bits >= 9'(ENTROPY_TARGET)) ? 10'd0
             : 10'(ENTROPY_TARGET) - {1'b0, credited_bits};
    if ({1'b0, item_bits} >= room) begin
      credit_next = 9'(ENTROPY_TARGET);
    end else begin
      credit_next = credited_bits + item_bits;
    end
    rd_pos  = 5'(6'(BUFFER_BYTES) - bytes_available);
    rd_word = out_buffer[rd_pos[4:2]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_req  <= s_axis_tuser;
      item_byte <= s_axis_tdata[7:0];
      item_last <= s_axis_tlast;
      item_bits <= s_axis_tdata[16:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // sigma constants in words 0 to 3, key, counter and nonce cleared
      cipher_state    <= {{12{32'd0}}, SIGMA3, SIGMA2, SIGMA1, SIGMA0};
      bytes_available <= '0;
      credited_bits   <= '0;
      batch_position  <= '0;
      rotate_phase    <= '0;
    end else begin
      unique case (state)
        ST_MIX_KEY: begin
          cipher_state[key_idx] <= cipher_state[key_idx] ^ mix_word;
        end
        ST_MIX_STIR: begin
          cipher_state[14] <= cipher_state[14] ^ (cipher_state[key_idx] + cipher_state[15]);
          cipher_state[15] <= rotl32(cipher_state[15] ^ {24'd0, item_byte}, STIR_ROT);
          if (item_last) begin
            credited_bits   <= credit_next;
            bytes_available <= '0;
            batch_position  <= '0;
            rotate_phase    <= '0;
          end else begin
            batch_position <= batch_position + 32'd1;
            rotate_phase   <= (rotate_phase >= 5'(PHASE_MOD - 1)) ? 5'd0
                            : rotate_phase + 5'd1;
          end
        end
        ST_REFILL: begin
          if (core_status.done) begin
            // key erasure: first half of the block folds back into the key words
            for (int i = 0; i < 8; i++) begin
              cipher_state[4 + i] <= cipher_state[4 + i] ^ core_block[i];
            end
            cipher_state[12] <= cipher_state[12] + 32'd1;
            if (cipher_state[12] == '1) begin
              cipher_state[13] <= cipher_state[13] + 32'd1;
            end
            bytes_available <= 6'(BUFFER_BYTES);
          end
        end
        ST_READ: begin
          bytes_available <= bytes_available - 6'd1;
        end
        ST_IDLE, ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REFILL && core_status.done) begin
      for (int i = 0; i < 8; i++) begin
        out_buffer[i] <= core_block[8 + i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      res_byte <= 8'(rd_word >> {rd_pos[1:0], 3'b000});
    end else if (state == ST_MIX_STIR) begin
      res_byte <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, credited_bits,
                       (credited_bits >= 9'(ENTROPY_TARGET)), res_byte};
    end
  end

  // a block result only lands while a refill is pending
  a_done_in_refill: assert property (@(posedge clk) disable iff (rst)
    core_status.done |-> state == ST_REFILL)
    else $error("block core finished outside a refill");

  // no new item while the core still runs
  a_idle_core: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !core_status.busy)
    else $error("input taken while block core busy");

  // a request only reads a filled buffer
  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (bytes_available != 6'd0 && item_req))
    else $error("buffer read with no bytes available");

  // the credit never passes the target
  a_credit_cap: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_DONE) && !item_req |=> credited_bits <= 9'(ENTROPY_TARGET))
    else $error("entropy credit above target");

endmodule
